// ===== design/qpd_pkg.sv =====
`timescale 1ns / 1ps

package qpd_pkg;

    localparam int KEY_MAX_BYTES = 16;
    localparam int KEY_POS_W     = 5;
    localparam int KEY_BITS      = 8 * KEY_MAX_BYTES;
    localparam int LIMIT_W       = 9;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] CFG_KEY_LOW   = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH  = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN   = 2'd2;
    localparam logic [1:0] CFG_VAL_LIMIT = 2'd3;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_VALUE  = 2'd1,
        PH_IGNORE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       found;
        logic       value_done;
    } out_word_t;

    // one or two result words caused by a single input byte
    typedef struct packed {
        logic      second;
        out_word_t res0;
        out_word_t res1;
    } pair_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key_bytes;
        logic [KEY_POS_W-1:0] key_length;
        logic [LIMIT_W-1:0]   value_limit;
    } cfg_t;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] plus_to_space(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

// ===== design/qpd_front.sv =====
`timescale 1ns / 1ps

module qpd_front
    import qpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_data,
    input  cfg_t     cfg,
    input  logic     queue_full,
    output logic     push,
    output pair_t    push_data
);

    phase_t               phase_reg, phase_next;
    logic [KEY_POS_W-1:0] key_pos_reg, key_pos_next;
    logic                 match_reg, match_next;
    logic [LIMIT_W-1:0]   raw_cnt_reg, raw_cnt_next;
    logic [1:0]           esc_cnt_reg, esc_cnt_next;
    logic [7:0]           esc_byte_reg, esc_byte_next;

    logic                 accept;
    logic [7:0]           b;
    logic                 last;
    logic [KEY_POS_W-1:0] eff_len;
    logic [LIMIT_W-1:0]   take_lim;
    logic [7:0]           key_ch;
    logic [LIMIT_W-1:0]   raw_inc;

    logic                 eq_hit;
    logic                 v_data;
    logic                 v_end;
    logic [1:0]           esc_step;
    logic [7:0]           esc_byte_step;
    logic [1:0]           esc_after;
    logic [7:0]           esc_byte_after;
    logic                 emit_a;
    logic [7:0]           byte_a;

    logic                 done;
    logic                 found;
    logic [1:0]           nb;
    logic [7:0]           byte0;
    logic [7:0]           byte1;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign b        = in_data.in_byte;
    assign last     = in_data.is_last;

    assign eff_len  = (cfg.key_length > KEY_POS_W'(KEY_MAX_BYTES))
                      ? KEY_POS_W'(KEY_MAX_BYTES) : cfg.key_length;
    assign take_lim = (cfg.value_limit == '0) ? '0 : cfg.value_limit - LIMIT_W'(1);
    assign key_ch   = cfg.key_bytes[{key_pos_reg[3:0], 3'b000} +: 8];
    assign raw_inc  = raw_cnt_reg + LIMIT_W'(1);

    // classify the byte against the current phase
    always_comb
    begin
        eq_hit = (phase_reg == PH_SCAN) && (b != CH_AMP) && match_reg
                 && (key_pos_reg >= eff_len) && (b == CH_EQ);
        v_data = (phase_reg == PH_VALUE) && (b != CH_AMP);
        v_end  = (phase_reg == PH_VALUE)
                 && ((b == CH_AMP) || last || (raw_inc >= take_lim));

        esc_step      = esc_cnt_reg;
        esc_byte_step = esc_byte_reg;
        emit_a        = 1'b0;
        byte_a        = 8'd0;
        case (esc_cnt_reg)
            ESC_NONE:
            begin
                if (b == CH_PCT)
                    esc_step = ESC_PCT;
                else
                begin
                    emit_a = v_data;
                    byte_a = plus_to_space(b);
                end
            end
            ESC_PCT:
            begin
                esc_byte_step = b;
                esc_step      = ESC_DIGIT;
            end
            default:
            begin
                emit_a        = v_data;
                byte_a        = {hex_val(esc_byte_reg), hex_val(b)};
                esc_step      = ESC_NONE;
                esc_byte_step = 8'd0;
            end
        endcase
        esc_after      = v_data ? esc_step : esc_cnt_reg;
        esc_byte_after = v_data ? esc_byte_step : esc_byte_reg;
    end

    // result words for this byte
    always_comb
    begin
        done  = 1'b0;
        found = 1'b0;
        nb    = 2'd0;
        byte0 = 8'd0;
        byte1 = 8'd0;
        case (phase_reg)
            PH_SCAN:
            begin
                done  = (eq_hit && (take_lim == '0)) || last;
                found = eq_hit;
            end
            PH_VALUE:
            begin
                done  = v_end;
                found = v_end;
                if (emit_a)
                begin
                    nb    = 2'd1;
                    byte0 = byte_a;
                end
                else if (v_end && (esc_after != ESC_NONE))
                begin
                    // value cut short inside an escape: flush it as text
                    byte0 = CH_PCT;
                    byte1 = plus_to_space(esc_byte_after);
                    nb    = (esc_after == ESC_DIGIT) ? 2'd2 : 2'd1;
                end
            end
            default:
            begin
                done  = 1'b0;
                found = 1'b0;
            end
        endcase

        push_data.second = (nb == 2'd2);
        if (nb != 2'd0)
        begin
            push_data.res0.out_byte   = byte0;
            push_data.res0.byte_valid = 1'b1;
            push_data.res0.found      = found && done && (nb == 2'd1);
            push_data.res0.value_done = done && (nb == 2'd1);
        end
        else
        begin
            push_data.res0.out_byte   = 8'd0;
            push_data.res0.byte_valid = 1'b0;
            push_data.res0.found      = found;
            push_data.res0.value_done = done;
        end
        push_data.res1.out_byte   = byte1;
        push_data.res1.byte_valid = 1'b1;
        push_data.res1.found      = found && done;
        push_data.res1.value_done = done;
        push = accept && (done || (nb != 2'd0));
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        key_pos_next  = key_pos_reg;
        match_next    = match_reg;
        raw_cnt_next  = raw_cnt_reg;
        esc_cnt_next  = esc_cnt_reg;
        esc_byte_next = esc_byte_reg;
        if (accept)
        begin
            if (last)
            begin
                phase_next    = PH_SCAN;
                key_pos_next  = '0;
                match_next    = 1'b1;
                raw_cnt_next  = '0;
                esc_cnt_next  = ESC_NONE;
                esc_byte_next = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_SCAN:
                    begin
                        if (b == CH_AMP)
                        begin
                            key_pos_next = '0;
                            match_next   = 1'b1;
                        end
                        else if (match_reg)
                        begin
                            if (key_pos_reg < eff_len)
                            begin
                                if (b != key_ch)
                                    match_next = 1'b0;
                                key_pos_next = key_pos_reg + KEY_POS_W'(1);
                            end
                            else if (b == CH_EQ)
                            begin
                                phase_next    = (take_lim == '0) ? PH_IGNORE : PH_VALUE;
                                raw_cnt_next  = '0;
                                esc_cnt_next  = ESC_NONE;
                                esc_byte_next = 8'd0;
                            end
                            else
                                match_next = 1'b0;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (v_data)
                        begin
                            raw_cnt_next  = raw_inc;
                            esc_cnt_next  = esc_after;
                            esc_byte_next = esc_byte_after;
                        end
                        if (v_end)
                        begin
                            phase_next    = PH_IGNORE;
                            esc_cnt_next  = ESC_NONE;
                            esc_byte_next = 8'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SCAN;
            key_pos_reg  <= '0;
            match_reg    <= 1'b1;
            raw_cnt_reg  <= '0;
            esc_cnt_reg  <= ESC_NONE;
            esc_byte_reg <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            key_pos_reg  <= key_pos_next;
            match_reg    <= match_next;
            raw_cnt_reg  <= raw_cnt_next;
            esc_cnt_reg  <= esc_cnt_next;
            esc_byte_reg <= esc_byte_next;
        end
    end

endmodule

// ===== design/qpd_fifo.sv =====
`timescale 1ns / 1ps

module qpd_fifo
    import qpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pair_t push_data,
    input  logic  pop,
    output pair_t head,
    output logic  full,
    output logic  empty
);

    pair_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/qpd_back.sv =====
`timescale 1ns / 1ps

module qpd_back
    import qpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      queue_empty,
    input  pair_t     head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic      valid_reg, valid_next;
    logic      second_reg, second_next;
    out_word_t word_reg, word_next;
    out_word_t second_word_reg, second_word_next;
    logic      load;

    assign load      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = word_reg;

    // second word of a pair goes out before the next pair is popped
    always_comb
    begin
        valid_next       = valid_reg;
        second_next      = second_reg;
        word_next        = word_reg;
        second_word_next = second_word_reg;
        pop              = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                valid_next  = 1'b1;
                word_next   = second_word_reg;
                second_next = 1'b0;
            end
            else if (!queue_empty)
            begin
                pop              = 1'b1;
                valid_next       = 1'b1;
                word_next        = head.res0;
                second_next      = head.second;
                second_word_next = head.res1;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg        <= word_next;
        second_word_reg <= second_word_next;
    end

endmodule

// ===== design/query_param_extract_decode.sv =====
`timescale 1ns / 1ps

// Query parameter extractor with percent-decoding. Takes one query-string byte
// per cycle while in_stall is low (is_last on the final byte) and, for the
// first '&'-separated pair that starts with the configured key followed by
// '=', delivers the decoded value bytes; the string's last result word, which
// may carry a byte, has value_done set (found tells whether the key was seen).
// Throughput is one input byte per cycle while the queue is not full. A byte
// that ends a value inside a cut-short escape can make two result words, and
// the output register delivers one word per cycle when not stalled; a 4-entry
// queue between the parser and the output stage absorbs that and output stalls.
// Configuration registers are written through cfg_*, which never stalls, and
// must only be written while no string is in flight.

module query_param_extract_decode
    import qpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]          key_low_reg;
    logic [63:0]          key_high_reg;
    logic [KEY_POS_W-1:0] key_len_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    cfg_t                 cfg;

    logic  push;
    pair_t push_data;
    logic  pop;
    pair_t head;
    logic  queue_full;
    logic  queue_empty;

    assign cfg_ready       = 1'b1;
    assign cfg.key_bytes   = {key_high_reg, key_low_reg};
    assign cfg.key_length  = key_len_reg;
    assign cfg.value_limit = limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
            limit_reg    <= LIMIT_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LOW:   key_low_reg  <= cfg_data;
                CFG_KEY_HIGH:  key_high_reg <= cfg_data;
                CFG_KEY_LEN:   key_len_reg  <= cfg_data[KEY_POS_W-1:0];
                CFG_VAL_LIMIT: limit_reg    <= cfg_data[LIMIT_W-1:0];
                default:       key_low_reg  <= key_low_reg;
            endcase
        end
    end

    qpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    qpd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    qpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ===== design/qpd_checker.sv =====
`timescale 1ns / 1ps

module qpd_checker
    import qpd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    // a held word is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // a word without a byte only ever closes a string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.value_done)
        else $error("empty word that is not the done word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.value_done)
        else $error("found set on a word other than the done word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
        else $error("nonzero out_byte on a word without a byte");

endmodule

bind query_param_extract_decode qpd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
